FILE: rtl/rpfl_pkg.sv
// shared types and constants of the record pool free list allocator
`timescale 1ns / 1ps

package rpfl_pkg;

  // fixed slot space of the pool and the free stack depth ceiling
  localparam int SLOT_SPACE = 1024;
  localparam int SLOT_W     = 10;
  localparam int DEPTH_W    = 11;
  localparam int DEPTH_MAX  = 2047;
  localparam int END_W      = 12;
  localparam int RPB_W      = 7;
  localparam int LIM_W      = 5;

  // configuration register indexes
  localparam logic CFG_RPB   = 1'b0;
  localparam logic CFG_LIMIT = 1'b1;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_FREE    = 2'd1,
    OP_RELEASE = 2'd2,
    OP_VERIFY  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EXHAUSTED = 2'd1,
    ST_NOT_POOL  = 2'd2,
    ST_SLOT_FREE = 2'd3
  } status_t;

  // source of the granted slot
  typedef enum logic [1:0] {
    GR_NONE = 2'd0,
    GR_HEAD = 2'd1,
    GR_UNT  = 2'd2,
    GR_END  = 2'd3
  } grant_t;

  typedef enum logic [2:0] {
    S_IDLE      = 3'd0,
    S_EXEC      = 3'd1,
    S_POP_WAIT  = 3'd2,
    S_WALK_CMP  = 3'd3,
    S_WALK_WAIT = 3'd4,
    S_RESP      = 3'd5
  } state_t;

  // datapath conditions seen by the sequencer
  typedef struct packed {
    logic in_go;
    op_t  op;
    logic depth_nz;
    logic unt_avail;
    logic can_grow;
    logic slot_ge_end;
    logic slot_ge_unt;
    logic walk_done;
    logic walk_hit;
    logic out_free;
  } flags_t;

  // sequencer commands to the datapath
  typedef struct packed {
    logic    accept;
    logic    pop_rd;
    logic    pop_ld;
    logic    take_unt;
    logic    grow;
    logic    push;
    logic    clear;
    logic    walk_start;
    logic    walk_rd;
    logic    walk_step;
    logic    res_set;
    logic    res_ok;
    status_t res_status;
    grant_t  grant_sel;
    logic    emit;
  } ctrl_t;

endpackage

FILE: rtl/rpfl_ram.sv
// generic single write port, single read port ram with registered read
`timescale 1ns / 1ps

module rpfl_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/rpfl_ctrl.sv
// sequencer of the allocator: state register, next state and commands
`timescale 1ns / 1ps

module rpfl_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  rpfl_pkg::flags_t flags,
  output rpfl_pkg::ctrl_t  ctrl
);

  rpfl_pkg::state_t state_r;
  rpfl_pkg::state_t state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rpfl_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rpfl_pkg::S_IDLE: begin
        if (flags.in_go) state_nxt = rpfl_pkg::S_EXEC;
      end
      rpfl_pkg::S_EXEC: begin
        case (flags.op)
          rpfl_pkg::OP_ALLOC: begin
            if (flags.depth_nz) state_nxt = rpfl_pkg::S_POP_WAIT;
            else state_nxt = rpfl_pkg::S_RESP;
          end
          rpfl_pkg::OP_VERIFY: begin
            if (flags.slot_ge_end || flags.slot_ge_unt) state_nxt = rpfl_pkg::S_RESP;
            else state_nxt = rpfl_pkg::S_WALK_CMP;
          end
          default: state_nxt = rpfl_pkg::S_RESP;
        endcase
      end
      rpfl_pkg::S_POP_WAIT: state_nxt = rpfl_pkg::S_RESP;
      rpfl_pkg::S_WALK_CMP: begin
        if (flags.walk_done || flags.walk_hit) state_nxt = rpfl_pkg::S_RESP;
        else state_nxt = rpfl_pkg::S_WALK_WAIT;
      end
      rpfl_pkg::S_WALK_WAIT: state_nxt = rpfl_pkg::S_WALK_CMP;
      rpfl_pkg::S_RESP: begin
        if (flags.out_free) state_nxt = rpfl_pkg::S_IDLE;
      end
      default: state_nxt = rpfl_pkg::S_IDLE;
    endcase
  end

  // commands
  always_comb begin
    ctrl = '0;
    case (state_r)
      rpfl_pkg::S_IDLE: ctrl.accept = 1'b1;
      rpfl_pkg::S_EXEC: begin
        case (flags.op)
          rpfl_pkg::OP_ALLOC: begin
            ctrl.res_set = 1'b1;
            if (flags.depth_nz) begin
              ctrl.pop_rd    = 1'b1;
              ctrl.res_ok    = 1'b1;
              ctrl.grant_sel = rpfl_pkg::GR_HEAD;
            end else if (flags.unt_avail) begin
              ctrl.take_unt  = 1'b1;
              ctrl.res_ok    = 1'b1;
              ctrl.grant_sel = rpfl_pkg::GR_UNT;
            end else if (flags.can_grow) begin
              ctrl.grow      = 1'b1;
              ctrl.res_ok    = 1'b1;
              ctrl.grant_sel = rpfl_pkg::GR_END;
            end else begin
              ctrl.res_status = rpfl_pkg::ST_EXHAUSTED;
            end
          end
          rpfl_pkg::OP_FREE: begin
            ctrl.push    = 1'b1;
            ctrl.res_set = 1'b1;
            ctrl.res_ok  = 1'b1;
          end
          rpfl_pkg::OP_RELEASE: begin
            ctrl.clear   = 1'b1;
            ctrl.res_set = 1'b1;
            ctrl.res_ok  = 1'b1;
          end
          rpfl_pkg::OP_VERIFY: begin
            if (flags.slot_ge_end) begin
              ctrl.res_set    = 1'b1;
              ctrl.res_status = rpfl_pkg::ST_NOT_POOL;
            end else if (flags.slot_ge_unt) begin
              ctrl.res_set    = 1'b1;
              ctrl.res_status = rpfl_pkg::ST_SLOT_FREE;
            end else begin
              ctrl.walk_start = 1'b1;
            end
          end
          default: ctrl.res_set = 1'b1;
        endcase
      end
      rpfl_pkg::S_POP_WAIT: ctrl.pop_ld = 1'b1;
      rpfl_pkg::S_WALK_CMP: begin
        if (flags.walk_done) begin
          ctrl.res_set = 1'b1;
          ctrl.res_ok  = 1'b1;
        end else if (flags.walk_hit) begin
          ctrl.res_set    = 1'b1;
          ctrl.res_status = rpfl_pkg::ST_SLOT_FREE;
        end else begin
          ctrl.walk_rd = 1'b1;
        end
      end
      rpfl_pkg::S_WALK_WAIT: ctrl.walk_step = 1'b1;
      rpfl_pkg::S_RESP: ctrl.emit = flags.out_free;
      default: ctrl = '0;
    endcase
  end

endmodule

FILE: rtl/record_pool_free_list_allocator.sv
// top level of the record pool free list allocator: datapath, link ram, sequencer
`timescale 1ns / 1ps

// Hands out fixed-size record slots by index from a pool that grows in blocks.
// Input channel: in_valid/in_stall with in_op (alloc, free, release all, verify)
// and in_slot_index. One word is taken only while the sequencer is idle.
// Result channel: out_valid/out_stall, one result word per input word, held in
// an output register so the next input word is taken while a result waits.
// Configuration: cfg_valid/cfg_ready write channel, index 0 records per block,
// index 1 block limit; cfg_ready is always high; write only while idle.
// From acceptance to out_valid, alloc from untouched slots or a new block, free,
// release and short verify pass the execute and response steps; an alloc that
// pops the free stack adds a pop wait step; a verify that follows links of the
// free stack runs compare steps, each link read followed by a wait step. The link
// ram read, one port registered, is why pops and walk steps need their wait steps.
// The next word is taken the cycle after the result leaves the sequencer.
// Reset (rst_n low, synchronous) empties the free stack, makes block 0 and
// loads records per block 64 and block limit 16; the link ram is not cleared.
// While out_stall is high the result is held and the sequencer waits in its
// response step once a second result is ready.

module record_pool_free_list_allocator #(
  parameter int MAX_BLOCKS        = 16,
  parameter int MAX_BLOCK_RECORDS = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_op,
  input  logic [9:0] in_slot_index,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_ok,
  output logic [9:0] out_granted_slot,
  output logic [1:0] out_status,
  output logic [4:0] out_blocks_in_use,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_index,
  input  logic [6:0] cfg_data
);

  localparam int LIM_CAP = (MAX_BLOCKS > 31) ? 31 : MAX_BLOCKS;

  rpfl_pkg::flags_t flags;
  rpfl_pkg::ctrl_t  ctrl;

  logic [rpfl_pkg::RPB_W-1:0]   rpb_r;
  logic [rpfl_pkg::LIM_W-1:0]   lim_r;
  logic [rpfl_pkg::RPB_W-1:0]   r_eff;
  logic [rpfl_pkg::LIM_W-1:0]   l_eff;

  rpfl_pkg::op_t                op_r, op_nxt;
  logic [rpfl_pkg::SLOT_W-1:0]  slot_r, slot_nxt;
  logic [rpfl_pkg::END_W-1:0]   end_r, end_nxt;
  logic [rpfl_pkg::SLOT_W-1:0]  head_r, head_nxt;
  logic [rpfl_pkg::DEPTH_W-1:0] depth_r, depth_nxt;
  logic [rpfl_pkg::DEPTH_W-1:0] unt_r, unt_nxt;
  logic [rpfl_pkg::LIM_W-1:0]   bm_r, bm_nxt;
  logic [rpfl_pkg::SLOT_W-1:0]  ptr_r, ptr_nxt;
  logic [rpfl_pkg::DEPTH_W-1:0] cnt_r, cnt_nxt;
  logic                         res_ok_r, res_ok_nxt;
  logic [rpfl_pkg::SLOT_W-1:0]  res_grant_r, res_grant_nxt;
  rpfl_pkg::status_t            res_status_r, res_status_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic                         out_ok_r, out_ok_nxt;
  logic [rpfl_pkg::SLOT_W-1:0]  out_grant_r, out_grant_nxt;
  logic [1:0]                   out_status_r, out_status_nxt;
  logic [rpfl_pkg::LIM_W-1:0]   out_bm_r, out_bm_nxt;

  logic                         ram_re;
  logic [rpfl_pkg::SLOT_W-1:0]  ram_raddr;
  logic [rpfl_pkg::SLOT_W-1:0]  ram_rdata;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rpb_r <= 7'd64;
      lim_r <= 5'd16;
    end else if (cfg_valid) begin
      if (cfg_index == rpfl_pkg::CFG_RPB) rpb_r <= cfg_data;
      if (cfg_index == rpfl_pkg::CFG_LIMIT) lim_r <= cfg_data[4:0];
    end
  end

  // effective records per block and block limit
  always_comb begin
    r_eff = rpb_r;
    if (rpb_r == '0) r_eff = 7'd1;
    else if (32'(rpb_r) > MAX_BLOCK_RECORDS) r_eff = 7'(MAX_BLOCK_RECORDS);
    l_eff = lim_r;
    if (lim_r == '0) l_eff = 5'd1;
    else if (32'(lim_r) > LIM_CAP) l_eff = 5'(LIM_CAP);
  end

  // conditions for the sequencer
  always_comb begin
    flags.in_go       = in_valid;
    flags.op          = op_r;
    flags.depth_nz    = (depth_r != '0);
    flags.unt_avail   = (12'(unt_r) < end_r) &&
                        (unt_r < 11'(rpfl_pkg::SLOT_SPACE));
    flags.can_grow    = (bm_r < l_eff) &&
                        ((13'(end_r) + 13'(r_eff)) <= 13'(rpfl_pkg::SLOT_SPACE));
    flags.slot_ge_end = (12'(slot_r) >= end_r);
    flags.slot_ge_unt = (11'(slot_r) >= unt_r);
    flags.walk_done   = (cnt_r == depth_r);
    flags.walk_hit    = (ptr_r == slot_r);
    flags.out_free    = !out_valid_r || !out_stall;
  end

  rpfl_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .ctrl  (ctrl)
  );

  // link ram: one write per free, one read per pop or walk step
  assign ram_re    = ctrl.pop_rd || ctrl.walk_rd;
  assign ram_raddr = ctrl.pop_rd ? head_r : ptr_r;

  rpfl_ram #(
    .WIDTH (rpfl_pkg::SLOT_W),
    .DEPTH (rpfl_pkg::SLOT_SPACE)
  ) u_link_ram (
    .clk   (clk),
    .we    (ctrl.push),
    .waddr (slot_r),
    .wdata (head_r),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // datapath next values
  always_comb begin
    op_nxt         = op_r;
    slot_nxt       = slot_r;
    end_nxt        = end_r;
    head_nxt       = head_r;
    depth_nxt      = depth_r;
    unt_nxt        = unt_r;
    bm_nxt         = bm_r;
    ptr_nxt        = ptr_r;
    cnt_nxt        = cnt_r;
    res_ok_nxt     = res_ok_r;
    res_grant_nxt  = res_grant_r;
    res_status_nxt = res_status_r;
    out_ok_nxt     = out_ok_r;
    out_grant_nxt  = out_grant_r;
    out_status_nxt = out_status_r;
    out_bm_nxt     = out_bm_r;
    out_valid_nxt  = out_valid_r && out_stall;

    // capture the word and the current pool end
    if (ctrl.accept && in_valid) begin
      op_nxt   = rpfl_pkg::op_t'(in_op);
      slot_nxt = in_slot_index;
      end_nxt  = 12'(bm_r) * 12'(r_eff);
    end

    // alloc paths
    if (ctrl.take_unt) unt_nxt = unt_r + 11'd1;
    if (ctrl.grow) begin
      unt_nxt = end_r[10:0] + 11'd1;
      bm_nxt  = bm_r + 5'd1;
    end
    if (ctrl.pop_ld) begin
      head_nxt  = ram_rdata;
      depth_nxt = depth_r - 11'd1;
    end

    // free pushes onto the stack, depth saturates
    if (ctrl.push) begin
      head_nxt = slot_r;
      if (depth_r != 11'(rpfl_pkg::DEPTH_MAX)) depth_nxt = depth_r + 11'd1;
    end

    // release all
    if (ctrl.clear) begin
      head_nxt  = '0;
      depth_nxt = '0;
      unt_nxt   = '0;
      bm_nxt    = 5'd1;
    end

    // stack walk for verify
    if (ctrl.walk_start) begin
      ptr_nxt = head_r;
      cnt_nxt = '0;
    end
    if (ctrl.walk_step) begin
      ptr_nxt = ram_rdata;
      cnt_nxt = cnt_r + 11'd1;
    end

    // result capture
    if (ctrl.res_set) begin
      res_ok_nxt     = ctrl.res_ok;
      res_status_nxt = ctrl.res_status;
      case (ctrl.grant_sel)
        rpfl_pkg::GR_HEAD: res_grant_nxt = head_r;
        rpfl_pkg::GR_UNT:  res_grant_nxt = unt_r[9:0];
        rpfl_pkg::GR_END:  res_grant_nxt = end_r[9:0];
        default:           res_grant_nxt = '0;
      endcase
    end

    // output register
    if (ctrl.emit) begin
      out_valid_nxt  = 1'b1;
      out_ok_nxt     = res_ok_r;
      out_grant_nxt  = res_grant_r;
      out_status_nxt = res_status_r;
      out_bm_nxt     = bm_r;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      depth_r     <= '0;
      unt_r       <= '0;
      bm_r        <= 5'd1;
      out_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      depth_r     <= depth_nxt;
      unt_r       <= unt_nxt;
      bm_r        <= bm_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    slot_r       <= slot_nxt;
    end_r        <= end_nxt;
    ptr_r        <= ptr_nxt;
    cnt_r        <= cnt_nxt;
    res_ok_r     <= res_ok_nxt;
    res_grant_r  <= res_grant_nxt;
    res_status_r <= res_status_nxt;
    out_ok_r     <= out_ok_nxt;
    out_grant_r  <= out_grant_nxt;
    out_status_r <= out_status_nxt;
    out_bm_r     <= out_bm_nxt;
  end

  assign in_stall          = !ctrl.accept;
  assign out_valid         = out_valid_r;
  assign out_ok            = out_ok_r;
  assign out_granted_slot  = out_grant_r;
  assign out_status        = out_status_r;
  assign out_blocks_in_use = out_bm_r;

`ifndef NO_ASSERTIONS
  // blocks made stays between one and the capped limit
  a_bm_range: assert property (@(posedge clk) disable iff (!rst_n)
    (bm_r >= 5'd1) && (32'(bm_r) <= LIM_CAP))
    else $error("blocks made out of range");

  // an accepted word blocks the input until its result is done
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while busy");

  // a walk step only reads within the stack depth
  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.walk_rd |-> (cnt_r < depth_r))
    else $error("stack walk past depth");

  // a failed result grants no slot
  a_fail_no_grant: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ok) |-> (out_granted_slot == '0))
    else $error("grant on failed result");

  // a non-ok status never comes with ok set
  a_status_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != rpfl_pkg::ST_OK)) |-> !out_ok)
    else $error("ok with error status");
`endif

endmodule

FILE: test/record_pool_free_list_allocator_test.sv
// testbench of the record pool free list allocator with a self-checking pool predictor
`timescale 1ns / 1ps

module record_pool_free_list_allocator_test;

  localparam int MAX_BLOCKS        = 16;
  localparam int MAX_BLOCK_RECORDS = 64;
  localparam int LONG_HOLD         = 300;
  localparam int SETTLE_CYCLES     = 4;

  typedef struct packed {
    logic              ok;
    logic [9:0]        granted;
    rpfl_pkg::status_t status;
    logic [4:0]        blocks;
  } pool_result_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [1:0] in_op;
  logic [9:0] in_slot_index;
  logic       out_valid;
  logic       out_stall;
  logic       out_ok;
  logic [9:0] out_granted_slot;
  logic [1:0] out_status;
  logic [4:0] out_blocks_in_use;
  logic       cfg_valid;
  logic       cfg_ready;
  logic       cfg_index;
  logic [6:0] cfg_data;

  // predicted pool state and register copies
  logic [9:0]   link_mem [0:rpfl_pkg::SLOT_SPACE-1];
  int           free_top;
  int           free_count;
  int           next_fresh;
  int           blocks_open;
  int           rpb_setting;
  int           limit_setting;

  pool_result_t pending_results[$];
  int           held_slots[$];
  int           mismatches;
  bit           send_gaps;
  bit           recv_gaps;
  bit           long_hold_req;

  record_pool_free_list_allocator #(
    .MAX_BLOCKS(MAX_BLOCKS),
    .MAX_BLOCK_RECORDS(MAX_BLOCK_RECORDS)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_op(in_op),
    .in_slot_index(in_slot_index),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_ok(out_ok),
    .out_granted_slot(out_granted_slot),
    .out_status(out_status),
    .out_blocks_in_use(out_blocks_in_use),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #20_000_000;
    $display("FAILURE");
    $finish;
  end

  // pool behavior for one accepted word; updates the predicted state
  function automatic pool_result_t pool_outcome(input logic [1:0] op, input logic [9:0] slot);
    pool_result_t res;
    int r, lim, fit, span_end, p, i;
    bit found;
    res = '0;
    res.status = rpfl_pkg::ST_OK;
    r = rpb_setting;
    if (r == 0) r = 1;
    if (r > MAX_BLOCK_RECORDS) r = MAX_BLOCK_RECORDS;
    span_end = blocks_open * r;
    case (op)
      rpfl_pkg::OP_ALLOC: begin
        // effective block limit after clamping
        lim = limit_setting;
        fit = rpfl_pkg::SLOT_SPACE / r;
        if (lim == 0) lim = 1;
        if (lim > MAX_BLOCKS) lim = MAX_BLOCKS;
        if (lim > 31) lim = 31;
        if (fit < 1) fit = 1;
        if (lim > fit) lim = fit;
        if (free_count > 0) begin
          res.granted = 10'(free_top);
          free_top = link_mem[free_top];
          free_count--;
          res.ok = 1'b1;
        end else if (next_fresh < span_end && next_fresh < rpfl_pkg::SLOT_SPACE) begin
          res.granted = 10'(next_fresh);
          next_fresh++;
          res.ok = 1'b1;
        end else if (blocks_open < lim && span_end + r <= rpfl_pkg::SLOT_SPACE) begin
          res.granted = 10'(span_end);
          next_fresh = span_end + 1;
          blocks_open++;
          res.ok = 1'b1;
        end else begin
          res.status = rpfl_pkg::ST_EXHAUSTED;
        end
      end
      rpfl_pkg::OP_FREE: begin
        link_mem[slot] = 10'(free_top);
        free_top = slot;
        if (free_count < rpfl_pkg::DEPTH_MAX) free_count++;
        res.ok = 1'b1;
      end
      rpfl_pkg::OP_RELEASE: begin
        free_top = 0;
        free_count = 0;
        next_fresh = 0;
        blocks_open = 1;
        res.ok = 1'b1;
      end
      default: begin
        if (slot >= span_end) begin
          res.status = rpfl_pkg::ST_NOT_POOL;
        end else if (slot >= next_fresh) begin
          res.status = rpfl_pkg::ST_SLOT_FREE;
        end else begin
          // walk the free stack for the slot
          p = free_top;
          found = 1'b0;
          for (i = 0; i < free_count; i++) begin
            if (p == slot) begin
              found = 1'b1;
              break;
            end
            p = link_mem[p];
          end
          if (found) res.status = rpfl_pkg::ST_SLOT_FREE;
          else res.ok = 1'b1;
        end
      end
    endcase
    res.blocks = 5'(blocks_open);
    return res;
  endfunction

  // send one word and record what it should produce
  task automatic send_word(input logic [1:0] op, input logic [9:0] slot);
    pool_result_t want;
    int k;
    if (send_gaps && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_op         <= op;
    in_slot_index <= slot;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    want = pool_outcome(op, slot);
    pending_results.push_back(want);
    // track handed-out slots to steer frees and verifies
    if (op == rpfl_pkg::OP_ALLOC && want.ok) begin
      held_slots.push_back(want.granted);
    end else if (op == rpfl_pkg::OP_FREE) begin
      for (k = 0; k < held_slots.size(); k++) begin
        if (held_slots[k] == slot) begin
          held_slots.delete(k);
          break;
        end
      end
    end else if (op == rpfl_pkg::OP_RELEASE) begin
      held_slots.delete();
    end
  endtask

  // stop sending until every result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // register write while the block is idle
  task automatic write_register(input logic idx, input logic [6:0] val);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    if (idx == rpfl_pkg::CFG_RPB) rpb_setting = val;
    else limit_setting = val[4:0];
    cfg_valid <= 1'b0;
  endtask

  // field extremes, every op, double and foreign frees, release
  task automatic test_directed_ops();
    drain_results();
    send_word(rpfl_pkg::OP_VERIFY, 10'd0);
    send_word(rpfl_pkg::OP_VERIFY, 10'd1023);
    send_word(rpfl_pkg::OP_ALLOC, 10'd0);
    send_word(rpfl_pkg::OP_ALLOC, 10'd1023);
    send_word(rpfl_pkg::OP_VERIFY, 10'd0);
    send_word(rpfl_pkg::OP_FREE, 10'd0);
    send_word(rpfl_pkg::OP_VERIFY, 10'd0);
    send_word(rpfl_pkg::OP_ALLOC, 10'h2AA);
    send_word(rpfl_pkg::OP_FREE, 10'd1023);
    send_word(rpfl_pkg::OP_FREE, 10'd1023);
    send_word(rpfl_pkg::OP_ALLOC, 10'h155);
    send_word(rpfl_pkg::OP_ALLOC, 10'd0);
    send_word(rpfl_pkg::OP_ALLOC, 10'd0);
    send_word(rpfl_pkg::OP_VERIFY, 10'd1);
    send_word(rpfl_pkg::OP_RELEASE, 10'd1023);
    send_word(rpfl_pkg::OP_ALLOC, 10'd0);
    send_word(rpfl_pkg::OP_VERIFY, 10'd0);
  endtask

  // smallest pool, exhaustion, then growth by one block
  task automatic test_exhaustion_and_growth();
    drain_results();
    send_word(rpfl_pkg::OP_RELEASE, 10'd0);
    write_register(rpfl_pkg::CFG_RPB, 7'd1);
    write_register(rpfl_pkg::CFG_LIMIT, 7'd1);
    send_word(rpfl_pkg::OP_ALLOC, 10'd0);
    send_word(rpfl_pkg::OP_ALLOC, 10'd0);
    send_word(rpfl_pkg::OP_VERIFY, 10'd0);
    send_word(rpfl_pkg::OP_VERIFY, 10'd1);
    write_register(rpfl_pkg::CFG_LIMIT, 7'd2);
    send_word(rpfl_pkg::OP_ALLOC, 10'd0);
    send_word(rpfl_pkg::OP_ALLOC, 10'd0);
    send_word(rpfl_pkg::OP_VERIFY, 10'd1);
    // out of range register values get clamped
    write_register(rpfl_pkg::CFG_RPB, 7'd0);
    write_register(rpfl_pkg::CFG_LIMIT, 7'd0);
    send_word(rpfl_pkg::OP_ALLOC, 10'd0);
    send_word(rpfl_pkg::OP_RELEASE, 10'd0);
    send_word(rpfl_pkg::OP_ALLOC, 10'd0);
    send_word(rpfl_pkg::OP_ALLOC, 10'd0);
  endtask

  // block size changed while blocks are in use
  task automatic test_resize_with_live_blocks();
    int n;
    drain_results();
    send_word(rpfl_pkg::OP_RELEASE, 10'd0);
    write_register(rpfl_pkg::CFG_RPB, 7'd1);
    write_register(rpfl_pkg::CFG_LIMIT, 7'd16);
    for (n = 0; n < 5; n++) send_word(rpfl_pkg::OP_ALLOC, 10'd0);
    write_register(rpfl_pkg::CFG_RPB, 7'd64);
    send_word(rpfl_pkg::OP_VERIFY, 10'd100);
    send_word(rpfl_pkg::OP_VERIFY, 10'd3);
    send_word(rpfl_pkg::OP_VERIFY, 10'd400);
    send_word(rpfl_pkg::OP_ALLOC, 10'd0);
    send_word(rpfl_pkg::OP_FREE, 10'd2);
    send_word(rpfl_pkg::OP_ALLOC, 10'd0);
    send_word(rpfl_pkg::OP_RELEASE, 10'd0);
  endtask

  // receiver holds off long while words keep coming
  task automatic test_backpressure();
    int n;
    drain_results();
    send_gaps = 1'b0;
    long_hold_req = 1'b1;
    for (n = 0; n < 24; n++) begin
      if (n % 3 == 2 && held_slots.size() != 0)
        send_word(rpfl_pkg::OP_FREE, 10'(held_slots[0]));
      else send_word(rpfl_pkg::OP_ALLOC, 10'($urandom_range(0, 1023)));
    end
    send_gaps = 1'b1;
    drain_results();
  endtask

  // deep free stack of random frees, long walks, popping it empty and past
  task automatic test_free_stack_deep();
    int n;
    drain_results();
    send_gaps = 1'b0;
    recv_gaps = 1'b0;
    send_word(rpfl_pkg::OP_RELEASE, 10'd0);
    for (n = 0; n < 20; n++) send_word(rpfl_pkg::OP_ALLOC, 10'd0);
    for (n = 0; n < 40; n++) send_word(rpfl_pkg::OP_FREE, 10'($urandom_range(0, 1023)));
    send_word(rpfl_pkg::OP_VERIFY, 10'd5);
    send_word(rpfl_pkg::OP_VERIFY, 10'd19);
    send_word(rpfl_pkg::OP_VERIFY, 10'($urandom_range(0, 19)));
    for (n = 0; n < 44; n++) send_word(rpfl_pkg::OP_ALLOC, 10'd0);
    send_word(rpfl_pkg::OP_RELEASE, 10'd0);
    send_gaps = 1'b1;
    recv_gaps = 1'b1;
    drain_results();
  endtask

  // mostly well-formed alloc and free traffic with verifies and some noise
  task automatic test_random_traffic(input logic [6:0] rpb, input logic [6:0] lim,
                                     input int count);
    int n, pick;
    logic [9:0] s;
    write_register(rpfl_pkg::CFG_RPB, rpb);
    write_register(rpfl_pkg::CFG_LIMIT, lim);
    for (n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      s = 10'($urandom_range(0, 1023));
      if (pick < 40) begin
        send_word(rpfl_pkg::OP_ALLOC, s);
      end else if (pick < 70) begin
        if (pick < 66 && held_slots.size() != 0)
          s = 10'(held_slots[$urandom_range(0, held_slots.size() - 1)]);
        send_word(rpfl_pkg::OP_FREE, s);
      end else if (pick < 97) begin
        if (pick < 85 && held_slots.size() != 0)
          s = 10'(held_slots[$urandom_range(0, held_slots.size() - 1)]);
        else if (pick < 91)
          s = 10'($urandom_range(0, 127));
        send_word(rpfl_pkg::OP_VERIFY, s);
      end else if (pick < 99) begin
        send_word(rpfl_pkg::OP_RELEASE, s);
      end else begin
        drain_results();
      end
    end
  endtask

  // receiver stall bursts and the long hold
  initial begin : result_stall
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        out_stall <= 1'b0;
      end else if (recv_gaps && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 13)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // compare each accepted result word with the oldest prediction
  always @(posedge clk) begin : check_results
    pool_result_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result word: ok=%0d slot=%0d status=%0d blocks=%0d",
                 $time, out_ok, out_granted_slot, out_status, out_blocks_in_use);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (out_ok !== want.ok) begin
          $display("%0t: ok expected %0d actual %0d", $time, want.ok, out_ok);
          mismatches++;
        end
        if (out_granted_slot !== want.granted) begin
          $display("%0t: granted_slot expected %0d actual %0d",
                   $time, want.granted, out_granted_slot);
          mismatches++;
        end
        if (out_status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, out_status);
          mismatches++;
        end
        if (out_blocks_in_use !== want.blocks) begin
          $display("%0t: blocks_in_use expected %0d actual %0d",
                   $time, want.blocks, out_blocks_in_use);
          mismatches++;
        end
      end
    end
  end

  initial begin : run_tests
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_op         = rpfl_pkg::OP_ALLOC;
    in_slot_index = '0;
    cfg_valid     = 1'b0;
    cfg_index     = rpfl_pkg::CFG_RPB;
    cfg_data      = '0;
    mismatches    = 0;
    send_gaps     = 1'b1;
    recv_gaps     = 1'b1;
    long_hold_req = 1'b0;
    // predicted state after reset
    free_top      = 0;
    free_count    = 0;
    next_fresh    = 0;
    blocks_open   = 1;
    rpb_setting   = 64;
    limit_setting = 16;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_ops();
    test_exhaustion_and_growth();
    test_resize_with_live_blocks();
    test_backpressure();
    test_free_stack_deep();
    test_random_traffic(7'd1, 7'd1, 120);
    test_random_traffic(7'd0, 7'd0, 100);
    test_random_traffic(7'd127, 7'd127, 150);
    test_random_traffic(7'd3, 7'd5, 150);
    test_random_traffic(7'd64, 7'd16, 150);
    test_random_traffic(7'd9, 7'd2, 150);
    test_random_traffic(7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)), 150);
    // last stretch with both sides streaming
    send_gaps = 1'b0;
    recv_gaps = 1'b0;
    test_random_traffic(7'd2, 7'd16, 100);
    drain_results();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: record_pool_free_list_allocator.f
rtl/rpfl_pkg.sv
rtl/rpfl_ram.sv
rtl/rpfl_ctrl.sv
rtl/record_pool_free_list_allocator.sv
test/record_pool_free_list_allocator_test.sv
